// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top level RTL file of the reverb block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of i_clk outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of i_clk outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/car_pkg.sv
// Package with the types, register indexes, constants and helpers of the reverb block.
`timescale 1ns / 1ps

package car_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_CLEAR = 12'b0000_0000_0010,
        S_PREP  = 12'b0000_0000_0100,
        S_C_RD  = 12'b0000_0000_1000,
        S_C_LP  = 12'b0000_0001_0000,
        S_C_WR  = 12'b0000_0010_0000,
        S_A_RD  = 12'b0000_0100_0000,
        S_A_WR  = 12'b0000_1000_0000,
        S_MIX1  = 12'b0001_0000_0000,
        S_MIX2  = 12'b0010_0000_0000,
        S_MIX3  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index CFG_ENABLED       = 3'd0;
    localparam t_cfg_index CFG_ROOM_SIZE     = 3'd1;
    localparam t_cfg_index CFG_DAMPING       = 3'd2;
    localparam t_cfg_index CFG_WET_MIX       = 3'd3;
    localparam t_cfg_index CFG_INPUT_GAIN    = 3'd4;
    localparam t_cfg_index CFG_WET_SCALE     = 3'd5;
    localparam t_cfg_index CFG_DAMPING_SCALE = 3'd6;

    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam logic [16:0] FB_BASE = 17'd18350;
    localparam logic [15:0] FB_ROOM = 16'd45875;
    localparam logic [16:0] FB_MAX  = 17'd64225;

    localparam logic [16:0] RST_ROOM_SIZE     = 17'd32768;
    localparam logic [16:0] RST_DAMPING       = 17'd32768;
    localparam logic [16:0] RST_WET_MIX       = 17'd19661;
    localparam logic [15:0] RST_INPUT_GAIN    = 16'd983;
    localparam logic [15:0] RST_WET_SCALE     = 16'd12288;
    localparam logic [16:0] RST_DAMPING_SCALE = 17'd26214;

    // Limits a Q1.16 register to one.
    function automatic logic [16:0] cap_one(input logic [16:0] v);
        cap_one = (v > Q16_ONE) ? Q16_ONE : v;
    endfunction

    // Saturates a wide signed value to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        if (v > 40'sd32767) begin
            sat16 = 16'sh7FFF;
        end else if (v < -40'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

endpackage

// File: hw/rtl/comb_allpass_reverb_top.sv
// Top level of the reverb block: four damped combs and two allpass stages on one delay memory.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+------------------------------
// input    | in        | i_in_valid / o_in_ready    | i_sample_in (16 bit signed)
// output   | out       | o_out_valid / i_out_ready  | o_sample_out (16 bit signed)
// config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index (3), i_cfg_data (17)
//
// An enabled item goes from acceptance to a loaded output register through a setup step,
// a read, lowpass and write step per comb and a read and write step per allpass on the
// single port pair of the delay memory, the mix steps and the output step. A bypassed
// item goes straight to the output step. After reset the delay memory is cleared one
// entry a cycle, all that the six lines hold together (5934 with the default lengths);
// no item is accepted meanwhile, while configuration writes are taken at any time.
// A finished item waits in the output register; the next item is accepted meanwhile and
// only stalls at its end if the earlier result has still not been taken.

module comb_allpass_reverb_top #(
    parameter int COMB_LEN_A    = 1116,
    parameter int COMB_LEN_B    = 1188,
    parameter int COMB_LEN_C    = 1277,
    parameter int COMB_LEN_D    = 1356,
    parameter int ALLPASS_LEN_A = 556,
    parameter int ALLPASS_LEN_B = 441
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_sample_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

    // All six delay lines share one memory, laid out back to back.
    localparam int BASE_CB = COMB_LEN_A;
    localparam int BASE_CC = BASE_CB + COMB_LEN_B;
    localparam int BASE_CD = BASE_CC + COMB_LEN_C;
    localparam int BASE_AA = BASE_CD + COMB_LEN_D;
    localparam int BASE_AB = BASE_AA + ALLPASS_LEN_A;
    localparam int TOTAL   = BASE_AB + ALLPASS_LEN_B;
    localparam int AW      = $clog2(TOTAL);

    localparam int CMAX1 = (COMB_LEN_A > COMB_LEN_B) ? COMB_LEN_A : COMB_LEN_B;
    localparam int CMAX2 = (COMB_LEN_C > COMB_LEN_D) ? COMB_LEN_C : COMB_LEN_D;
    localparam int CMAX  = (CMAX1 > CMAX2) ? CMAX1 : CMAX2;
    localparam int CPW   = (CMAX > 2) ? $clog2(CMAX) : 1;
    localparam int AMAX  = (ALLPASS_LEN_A > ALLPASS_LEN_B) ? ALLPASS_LEN_A : ALLPASS_LEN_B;
    localparam int APW   = (AMAX > 2) ? $clog2(AMAX) : 1;

    localparam int C_BASE [4] = '{0, BASE_CB, BASE_CC, BASE_CD};
    localparam int C_LEN  [4] = '{COMB_LEN_A, COMB_LEN_B, COMB_LEN_C, COMB_LEN_D};
    localparam int A_BASE [2] = '{BASE_AA, BASE_AB};
    localparam int A_LEN  [2] = '{ALLPASS_LEN_A, ALLPASS_LEN_B};

    // Configuration registers.
    logic        r_enabled;
    logic [16:0] r_room_size;
    logic [16:0] r_damping;
    logic [16:0] r_wet_mix;
    logic [15:0] r_input_gain;
    logic [15:0] r_wet_scale;
    logic [16:0] r_damping_scale;

    // Sequencer and per-item working registers.
    car_pkg::t_state r_state;
    logic [AW-1:0]   r_clr_addr;
    logic [1:0]      r_k;
    logic            r_j;
    logic [AW-1:0]   r_addr;
    logic [CPW-1:0]  r_cpos [4];
    logic [APW-1:0]  r_apos [2];
    logic signed [32:0] r_lp [4];
    logic signed [15:0] r_dry;
    logic signed [15:0] r_x;
    logic [16:0]        r_fb;
    logic [16:0]        r_d1;
    logic signed [17:0] r_sum;
    logic signed [15:0] r_ap;
    logic signed [20:0] r_wet;
    logic signed [33:0] r_pd;
    logic signed [38:0] r_pw;
    logic signed [15:0] r_res;
    logic               r_out_valid;
    logic signed [15:0] r_out;

    // Delay memory with a registered read.
    logic signed [15:0] r_mem [TOTAL];
    logic signed [15:0] r_rdata;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [15:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == car_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled       <= 1'b0;
            r_room_size     <= car_pkg::RST_ROOM_SIZE;
            r_damping       <= car_pkg::RST_DAMPING;
            r_wet_mix       <= car_pkg::RST_WET_MIX;
            r_input_gain    <= car_pkg::RST_INPUT_GAIN;
            r_wet_scale     <= car_pkg::RST_WET_SCALE;
            r_damping_scale <= car_pkg::RST_DAMPING_SCALE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                car_pkg::CFG_ENABLED:       r_enabled       <= i_cfg_data[0];
                car_pkg::CFG_ROOM_SIZE:     r_room_size     <= i_cfg_data;
                car_pkg::CFG_DAMPING:       r_damping       <= i_cfg_data;
                car_pkg::CFG_WET_MIX:       r_wet_mix       <= i_cfg_data;
                car_pkg::CFG_INPUT_GAIN:    r_input_gain    <= i_cfg_data[15:0];
                car_pkg::CFG_WET_SCALE:     r_wet_scale     <= i_cfg_data[15:0];
                car_pkg::CFG_DAMPING_SCALE: r_damping_scale <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Setup arithmetic: feedback, damping coefficients and the scaled input.
    logic [16:0]        room_c;
    logic [32:0]        room_prod;
    logic [16:0]        fb_raw;
    logic [33:0]        damp_prod;
    logic signed [32:0] x_prod;
    logic signed [32:0] x_trunc;
    logic [16:0]        d2;

    assign room_c    = car_pkg::cap_one(r_room_size);
    assign room_prod = room_c * car_pkg::FB_ROOM;
    assign fb_raw    = car_pkg::FB_BASE + room_prod[32:16];
    assign damp_prod = car_pkg::cap_one(r_damping) * car_pkg::cap_one(r_damping_scale);
    assign x_prod    = r_dry * $signed({1'b0, r_input_gain});
    assign x_trunc   = (x_prod + (x_prod[32] ? 33'sd65535 : 33'sd0)) >>> 16;
    assign d2        = car_pkg::Q16_ONE - r_d1;

    // Comb lowpass update: lp = out * d2 + trunc(lp * d1 / 2^16).
    logic signed [32:0] lp_cur;
    logic signed [33:0] lp_p1;
    logic signed [50:0] lp_p2;
    logic signed [50:0] lp_p2t;
    logic signed [34:0] lp_sum;

    assign lp_cur = r_lp[r_k];
    assign lp_p1  = r_rdata * $signed({1'b0, d2});
    assign lp_p2  = lp_cur * $signed({1'b0, r_d1});
    assign lp_p2t = (lp_p2 + (lp_p2[50] ? 51'sd65535 : 51'sd0)) >>> 16;
    assign lp_sum = 35'(lp_p1) + lp_p2t[34:0];

    // Comb write value: sat16(x + trunc(lp * fb / 2^32)).
    logic signed [50:0] fb_prod;
    logic signed [50:0] fb_trunc;
    logic signed [39:0] comb_w;

    assign fb_prod  = lp_cur * $signed({1'b0, r_fb});
    assign fb_trunc = (fb_prod + (fb_prod[50] ? 51'sd4294967295 : 51'sd0)) >>> 32;
    assign comb_w   = 40'($signed(fb_trunc[19:0])) + 40'(r_x);

    // Allpass: the first stage takes the floor mean of the comb outputs.
    logic signed [15:0] ap_x;
    logic signed [39:0] ap_w;
    logic signed [39:0] ap_o;

    assign ap_x = r_j ? r_ap : r_sum[17:2];
    assign ap_w = 40'(ap_x) + 40'(r_rdata >>> 1);
    assign ap_o = 40'(r_rdata) - 40'(ap_x);

    // Wet gain and crossfade.
    logic signed [32:0] wet_prod;
    logic signed [32:0] wet_trunc;
    logic [16:0]        mix_c;
    logic [16:0]        dmix;
    logic signed [39:0] mix_sum;
    logic signed [39:0] mix_trunc;

    assign wet_prod  = r_ap * $signed({1'b0, r_wet_scale});
    assign wet_trunc = (wet_prod + (wet_prod[32] ? 33'sd4095 : 33'sd0)) >>> 12;
    assign mix_c     = car_pkg::cap_one(r_wet_mix);
    assign dmix      = car_pkg::Q16_ONE - mix_c;
    assign mix_sum   = 40'(r_pw) + 40'(r_pd);
    assign mix_trunc = (mix_sum + (mix_sum[39] ? 40'sd65535 : 40'sd0)) >>> 16;

    logic [AW-1:0] comb_addr;
    logic [AW-1:0] ap_addr;

    assign comb_addr = AW'(C_BASE[r_k]) + AW'(r_cpos[r_k]);
    assign ap_addr   = AW'(A_BASE[r_j]) + AW'(r_apos[r_j]);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = car_pkg::sat16(comb_w);
        mem_raddr = comb_addr;
        case (r_state)
            car_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = 16'sd0;
            end
            car_pkg::S_C_WR: begin
                mem_we = 1'b1;
            end
            car_pkg::S_A_RD: begin
                mem_raddr = ap_addr;
            end
            car_pkg::S_A_WR: begin
                mem_we    = 1'b1;
                mem_wdata = car_pkg::sat16(ap_w);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= car_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_k         <= '0;
            r_j         <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_cpos[i] <= '0;
                r_lp[i]   <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_apos[i] <= '0;
            end
        end else begin
            // The output step handles its own valid flag, so only clear it elsewhere.
            if (r_out_valid && i_out_ready && (r_state != car_pkg::S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                car_pkg::S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(TOTAL - 1)) begin
                        r_state <= car_pkg::S_IDLE;
                    end
                end
                car_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_dry <= i_sample_in;
                        r_res <= i_sample_in;
                        r_k   <= '0;
                        r_j   <= 1'b0;
                        r_sum <= '0;
                        r_state <= r_enabled ? car_pkg::S_PREP : car_pkg::S_OUT;
                    end
                end
                car_pkg::S_PREP: begin
                    r_fb    <= (fb_raw > car_pkg::FB_MAX) ? car_pkg::FB_MAX : fb_raw;
                    r_d1    <= damp_prod[32:16];
                    r_x     <= x_trunc[15:0];
                    r_state <= car_pkg::S_C_RD;
                end
                car_pkg::S_C_RD: begin
                    r_addr  <= comb_addr;
                    r_state <= car_pkg::S_C_LP;
                end
                car_pkg::S_C_LP: begin
                    r_lp[r_k] <= lp_sum[32:0];
                    r_sum     <= r_sum + 18'(r_rdata);
                    r_state   <= car_pkg::S_C_WR;
                end
                car_pkg::S_C_WR: begin
                    if (r_cpos[r_k] == CPW'(C_LEN[r_k] - 1)) begin
                        r_cpos[r_k] <= '0;
                    end else begin
                        r_cpos[r_k] <= r_cpos[r_k] + 1'b1;
                    end
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k == 2'd3) ? car_pkg::S_A_RD : car_pkg::S_C_RD;
                end
                car_pkg::S_A_RD: begin
                    r_addr  <= ap_addr;
                    r_state <= car_pkg::S_A_WR;
                end
                car_pkg::S_A_WR: begin
                    r_ap <= car_pkg::sat16(ap_o);
                    if (r_apos[r_j] == APW'(A_LEN[r_j] - 1)) begin
                        r_apos[r_j] <= '0;
                    end else begin
                        r_apos[r_j] <= r_apos[r_j] + 1'b1;
                    end
                    r_j     <= 1'b1;
                    r_state <= r_j ? car_pkg::S_MIX1 : car_pkg::S_A_RD;
                end
                car_pkg::S_MIX1: begin
                    r_wet   <= wet_trunc[20:0];
                    r_state <= car_pkg::S_MIX2;
                end
                car_pkg::S_MIX2: begin
                    r_pd    <= r_dry * $signed({1'b0, dmix});
                    r_pw    <= r_wet * $signed({1'b0, mix_c});
                    r_state <= car_pkg::S_MIX3;
                end
                car_pkg::S_MIX3: begin
                    r_res   <= car_pkg::sat16(mix_trunc);
                    r_state <= car_pkg::S_OUT;
                end
                car_pkg::S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= car_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= car_pkg::S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_SAME(a_waddr_range, mem_we, mem_waddr < AW'(TOTAL), "memory write out of range")
    `ASSERT_NEXT(a_bypass_direct, i_in_valid && o_in_ready && !r_enabled,
                 r_state == car_pkg::S_OUT, "bypassed item did not go straight to output")
    `ASSERT_SAME(a_out_from_seq, $rose(o_out_valid), $past(r_state) == car_pkg::S_OUT,
                 "output valid rose outside the output step")

endmodule

// File: bench/comb_allpass_reverb_top_tb.sv
// Self-checking bench for the reverb top level: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module comb_allpass_reverb_top_tb;

    // Cycles with no handshake on any channel before the run is declared hung. The limit
    // sits well above both the memory clear after reset and the long receiver hold-off.
    localparam int WATCHDOG_LIMIT = 30000;
    // Quiet cycles granted after the last result, before a register write or the end.
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 1730;
    localparam int HOLD_CYCLES    = 600;

    // A register index that names no register.
    localparam car_pkg::t_cfg_index CFG_UNUSED = 3'd7;

    localparam int COMB_LEN [4]    = '{1116, 1188, 1277, 1356};
    localparam int ALLPASS_LEN [2] = '{556, 441};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic signed [15:0]  i_sample_in = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic signed [15:0]  o_sample_out;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    car_pkg::t_cfg_index i_cfg_index = car_pkg::CFG_ENABLED;
    logic [16:0]         i_cfg_data = '0;

    comb_allpass_reverb_top dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------------
    // Predictor state: its own copy of the registers and of every delay line.
    // ---------------------------------------------------------------------------------
    logic        rv_enabled       = 1'b0;
    logic [16:0] rv_room          = car_pkg::RST_ROOM_SIZE;
    logic [16:0] rv_damping       = car_pkg::RST_DAMPING;
    logic [16:0] rv_wet_mix       = car_pkg::RST_WET_MIX;
    logic [15:0] rv_input_gain    = car_pkg::RST_INPUT_GAIN;
    logic [15:0] rv_wet_scale     = car_pkg::RST_WET_SCALE;
    logic [16:0] rv_damping_scale = car_pkg::RST_DAMPING_SCALE;

    shortint comb_mem [4][2048];
    shortint allpass_mem [2][1024];
    int      comb_pos [4];
    int      allpass_pos [2];
    longint  comb_lp [4];

    initial begin
        foreach (comb_mem[k, j]) comb_mem[k][j] = 0;
        foreach (allpass_mem[k, j]) allpass_mem[k][j] = 0;
        foreach (comb_pos[k]) begin
            comb_pos[k] = 0;
            comb_lp[k] = 0;
        end
        foreach (allpass_pos[k]) allpass_pos[k] = 0;
    end

    function automatic longint clip16(input longint v);
        if (v > 32767) begin
            return 32767;
        end else if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic longint unity_limit(input logic [16:0] v);
        return (v > 17'd65536) ? 65536 : longint'(v);
    endfunction

    // One damped comb: read the oldest sample, update the lowpass, write back the
    // saturated sum of input and filtered feedback.
    function automatic longint comb_tap(input int k, input longint x, input longint fb,
                                        input longint d1, input longint d2);
        longint y;
        y = comb_mem[k][comb_pos[k]];
        comb_lp[k] = y * d2 + (comb_lp[k] * d1) / 65536;
        comb_mem[k][comb_pos[k]] = shortint'(clip16(x + (comb_lp[k] * fb) / (64'sd1 <<< 32)));
        comb_pos[k] = (comb_pos[k] + 1 == COMB_LEN[k]) ? 0 : comb_pos[k] + 1;
        return y;
    endfunction

    // One allpass stage with feedback of one half; the halving rounds toward minus infinity.
    function automatic longint allpass_tap(input int k, input longint x);
        longint b;
        b = allpass_mem[k][allpass_pos[k]];
        allpass_mem[k][allpass_pos[k]] = shortint'(clip16(x + (b >>> 1)));
        allpass_pos[k] = (allpass_pos[k] + 1 == ALLPASS_LEN[k]) ? 0 : allpass_pos[k] + 1;
        return clip16(b - x);
    endfunction

    function automatic logic signed [15:0] reverb_sample(input logic signed [15:0] dry_in);
        longint dry, fb, d1, d2, x, sum, ap, wet, mix;
        dry = dry_in;
        // In bypass the sample goes straight out and nothing inside moves.
        if (!rv_enabled) begin
            return dry_in;
        end
        fb = 18350 + ((unity_limit(rv_room) * 45875) >>> 16);
        if (fb > 64225) fb = 64225;
        d1 = (unity_limit(rv_damping) * unity_limit(rv_damping_scale)) >>> 16;
        d2 = 65536 - d1;
        x = (dry * longint'(rv_input_gain)) / 65536;
        sum = 0;
        for (int k = 0; k < 4; k++) sum += comb_tap(k, x, fb, d1, d2);
        // The arithmetic shift gives the floor of the mean of the four combs.
        ap = allpass_tap(0, sum >>> 2);
        ap = allpass_tap(1, ap);
        wet = (ap * longint'(rv_wet_scale)) / 4096;
        mix = unity_limit(rv_wet_mix);
        return 16'(clip16((dry * (65536 - mix) + wet * mix) / 65536));
    endfunction

    // ---------------------------------------------------------------------------------
    // Scoreboard.
    // ---------------------------------------------------------------------------------
    typedef struct packed {
        logic               fixed;
        logic signed [15:0] value;
    } typed_t;

    typed_t             typed_queue [$];   // One entry per item offered, in order.
    logic signed [15:0] expected_out [$];
    int                 error_count = 0;
    int                 items_in = 0;
    int                 idle_cycles = 0;

    task automatic report_mismatch(input string what, input logic signed [15:0] want,
                                   input logic signed [15:0] got);
        $display("[%0t] error: %s, expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    // Every handshake is observed at the rising edge, before the block's registers move.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    car_pkg::CFG_ENABLED:       rv_enabled       <= i_cfg_data[0];
                    car_pkg::CFG_ROOM_SIZE:     rv_room          <= i_cfg_data;
                    car_pkg::CFG_DAMPING:       rv_damping       <= i_cfg_data;
                    car_pkg::CFG_WET_MIX:       rv_wet_mix       <= i_cfg_data;
                    car_pkg::CFG_INPUT_GAIN:    rv_input_gain    <= i_cfg_data[15:0];
                    car_pkg::CFG_WET_SCALE:     rv_wet_scale     <= i_cfg_data[15:0];
                    car_pkg::CFG_DAMPING_SCALE: rv_damping_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                typed_t t;
                logic signed [15:0] p;
                t = typed_queue.pop_front();
                p = reverb_sample(i_sample_in);
                expected_out.push_back(t.fixed ? t.value : p);
                items_in++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_out.size() == 0) begin
                    report_mismatch("output item with none pending", 16'sd0, o_sample_out);
                end else begin
                    logic signed [15:0] w;
                    w = expected_out.pop_front();
                    if (w !== o_sample_out) report_mismatch("sample_out", w, o_sample_out);
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Receiver: random stalls, a quiet stretch, and one long hold-off that backs the
    // block up until it refuses new items.
    // ---------------------------------------------------------------------------------
    logic calm = 1'b0;

    initial begin
        int  hold;
        bit  held;
        hold = 0;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (!held && items_in >= 1000) begin
                held = 1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Sender side.
    // ---------------------------------------------------------------------------------
    task automatic send_item(input logic signed [15:0] s, input bit fixed,
                             input logic signed [15:0] want);
        typed_queue.push_back({fixed, want});
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 11) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Registers only change with the block idle: all results back, then a quiet spell.
    task automatic write_reg(input car_pkg::t_cfg_index idx, input logic [16:0] data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_out.size() != 0 || typed_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [16:0] pick_q16(input bit wide);
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return wide ? 17'd65536 : 17'd65535;
            2: return wide ? 17'h1FFFF : 17'd65535;
            default: return wide ? 17'($urandom_range(0, 70000)) : 17'($urandom_range(0, 65535));
        endcase
    endfunction

    typedef struct {
        bit                  is_cfg;
        car_pkg::t_cfg_index idx;
        logic [16:0]         data;
        logic signed [15:0]  smp;
        bit                  fixed;
        logic signed [15:0]  want;
    } step_t;

    // Directed table. Bypass rows and the two mix extremes carry their expected value;
    // the rest goes through the predictor.
    step_t directed [] = '{
        '{0, car_pkg::CFG_ENABLED,     17'd0,      16'sd0,      1, 16'sd0},
        '{0, car_pkg::CFG_ENABLED,     17'd0,      16'sd32767,  1, 16'sd32767},
        '{0, car_pkg::CFG_ENABLED,     17'd0,     -16'sd32768,  1, -16'sd32768},
        '{0, car_pkg::CFG_ENABLED,     17'd0,     -16'sd1,      1, -16'sd1},
        '{0, car_pkg::CFG_ENABLED,     17'd0,      16'sd21845,  1, 16'sd21845},
        '{0, car_pkg::CFG_ENABLED,     17'd0,     -16'sd21846,  1, -16'sd21846},
        // An unknown register index leaves the block in bypass.
        '{1, CFG_UNUSED,               17'd1,      16'sd0,      0, 16'sd0},
        '{0, car_pkg::CFG_ENABLED,     17'd0,      16'sd1234,   1, 16'sd1234},
        '{1, car_pkg::CFG_ENABLED,     17'd1,      16'sd0,      0, 16'sd0},
        '{0, car_pkg::CFG_ENABLED,     17'd0,      16'sd32767,  0, 16'sd0},
        '{0, car_pkg::CFG_ENABLED,     17'd0,     -16'sd32768,  0, 16'sd0},
        '{0, car_pkg::CFG_ENABLED,     17'd0,      16'sd0,      0, 16'sd0},
        '{0, car_pkg::CFG_ENABLED,     17'd0,      16'sd12345,  0, 16'sd0},
        // With no wet share the dry sample comes through untouched.
        '{1, car_pkg::CFG_WET_MIX,     17'd0,      16'sd0,      0, 16'sd0},
        '{0, car_pkg::CFG_ENABLED,     17'd0,      16'sd32767,  1, 16'sd32767},
        '{0, car_pkg::CFG_ENABLED,     17'd0,     -16'sd32768,  1, -16'sd32768},
        // Wet share above one is capped; with zero wet gain the output is silent.
        '{1, car_pkg::CFG_WET_SCALE,   17'd0,      16'sd0,      0, 16'sd0},
        '{1, car_pkg::CFG_WET_MIX,     17'h1FFFF,  16'sd0,      0, 16'sd0},
        '{0, car_pkg::CFG_ENABLED,     17'd0,      16'sd32767,  1, 16'sd0},
        // Extreme settings everywhere, checked by the predictor.
        '{1, car_pkg::CFG_ROOM_SIZE,   17'h1FFFF,  16'sd0,      0, 16'sd0},
        '{1, car_pkg::CFG_DAMPING,     17'd0,      16'sd0,      0, 16'sd0},
        '{1, car_pkg::CFG_DAMPING_SCALE, 17'd65536, 16'sd0,     0, 16'sd0},
        '{1, car_pkg::CFG_INPUT_GAIN,  17'd65535,  16'sd0,      0, 16'sd0},
        '{1, car_pkg::CFG_WET_SCALE,   17'd65535,  16'sd0,      0, 16'sd0},
        '{1, car_pkg::CFG_WET_MIX,     17'd32768,  16'sd0,      0, 16'sd0},
        '{0, car_pkg::CFG_ENABLED,     17'd0,     -16'sd32768,  0, 16'sd0},
        '{0, car_pkg::CFG_ENABLED,     17'd0,      16'sd32767,  0, 16'sd0},
        '{0, car_pkg::CFG_ENABLED,     17'd0,      16'sd100,    0, 16'sd0}
    };

    initial begin
        int per_phase;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[r]) begin
            if (directed[r].is_cfg) begin
                write_reg(directed[r].idx, directed[r].data);
            end else begin
                send_item(directed[r].smp, directed[r].fixed, directed[r].want);
            end
        end

        // Random phases: new settings, then a run of samples. Most phases reverberate.
        per_phase = RANDOM_ITEMS / 10;
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(car_pkg::CFG_ROOM_SIZE, pick_q16(1));
            write_reg(car_pkg::CFG_DAMPING, pick_q16(1));
            write_reg(car_pkg::CFG_WET_MIX, pick_q16(1));
            write_reg(car_pkg::CFG_INPUT_GAIN, pick_q16(0));
            write_reg(car_pkg::CFG_WET_SCALE, pick_q16(0));
            write_reg(car_pkg::CFG_DAMPING_SCALE, pick_q16(1));
            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 17'($urandom));
            write_reg(car_pkg::CFG_ENABLED,
                      (ph == 4) ? 17'd0 : 17'($urandom_range(0, 5) != 0));
            calm <= (ph == 3);
            for (int n = 0; n < per_phase; n++) begin
                logic signed [15:0] s;
                case ($urandom_range(0, 9))
                    0: s = 16'sh7FFF;
                    1: s = 16'sh8000;
                    2: s = 16'($signed(12'($urandom)));
                    default: s = 16'($urandom);
                endcase
                send_item(s, 0, 16'sd0);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        calm <= 1'b0;
        while (expected_out.size() != 0 || typed_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_out.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
